// ===== sv/slt_pkg.sv =====
// Shared types, constants and helper functions of the source lexer tokenizer.
`timescale 1ns / 1ps

package slt_pkg;

   // Default sizes of the identifier prefix and of the number mantissa
   localparam int PREFIX_CHARS_DEF    = 8;
   localparam int MANTISSA_DIGITS_DEF = 18;

   // Fixed field widths of the channels
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 4;
   localparam int PREFIX_W = 64;
   localparam int MANT_W   = 60;
   localparam int LINE_W   = 32;
   localparam int COL_W    = 16;

   // Token kinds
   localparam logic [KIND_W-1:0] TOK_EOF    = 4'd0;
   localparam logic [KIND_W-1:0] TOK_FUN    = 4'd1;
   localparam logic [KIND_W-1:0] TOK_IDENT  = 4'd11;
   localparam logic [KIND_W-1:0] TOK_NUM    = 4'd12;
   localparam logic [KIND_W-1:0] TOK_CHAR   = 4'd13;

   // Keywords, packed first character in the lowest byte
   localparam int KW_COUNT = 10;
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_006e_7566,   // fun
      48'h6e72_6574_7865,   // extern
      48'h7463_7572_7473,   // struct
      48'h0000_0000_6669,   // if
      48'h0000_6e65_6874,   // then
      48'h0000_6573_6c65,   // else
      48'h0000_0072_6f66,   // for
      48'h0000_0000_6e69,   // in
      48'h0000_0074_6e69,   // int
      48'h656c_6275_6f64    // double
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd3, 8'd6, 8'd6, 8'd2, 8'd4, 8'd4, 8'd3, 8'd2, 8'd3, 8'd6
   };

   // Special bytes
   localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2e;
   localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;

   // One result item as it waits in the result queue
   typedef struct packed {
      logic [KIND_W-1:0]   token_kind;
      logic [BYTE_W-1:0]   char_code;
      logic [PREFIX_W-1:0] ident_prefix;
      logic [7:0]          ident_length;
      logic [MANT_W-1:0]   mantissa;
      logic [7:0]          fraction_digits;
      logic                number_overflow;
      logic [LINE_W-1:0]   line_number;
      logic [COL_W-1:0]    column_number;
      logic                last;
   } slt_result_type;

   // Largest mantissa: 10^digits - 1
   function automatic logic [63:0] mant_max(input int digits);
      logic [63:0] m;
      m = 64'd1;
      for (int i = 0; i < digits; i++) begin
         m = m * 64'd10;
      end
      return m - 64'd1;
   endfunction

endpackage

// ===== sv/slt_req_if.sv =====
// Input channel of the source lexer tokenizer: one source byte or end mark.
`timescale 1ns / 1ps

interface slt_req_if;
   import slt_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] char_byte;
   logic              end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

// ===== sv/slt_rsp_if.sv =====
// Result channel of the source lexer tokenizer: one token per transfer.
`timescale 1ns / 1ps

interface slt_rsp_if;
   import slt_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   token_kind;
   logic [BYTE_W-1:0]   char_code;
   logic [PREFIX_W-1:0] ident_prefix;
   logic [7:0]          ident_length;
   logic [MANT_W-1:0]   mantissa;
   logic [7:0]          fraction_digits;
   logic                number_overflow;
   logic [LINE_W-1:0]   line_number;
   logic [COL_W-1:0]    column_number;
   logic                last;

   modport source (
      output valid, output token_kind, output char_code, output ident_prefix,
      output ident_length, output mantissa, output fraction_digits,
      output number_overflow, output line_number, output column_number,
      output last, input ready
   );
   modport sink (
      input valid, input token_kind, input char_code, input ident_prefix,
      input ident_length, input mantissa, input fraction_digits,
      input number_overflow, input line_number, input column_number,
      input last, output ready
   );
endinterface

// ===== sv/source_lexer_tokenizer_core.sv =====
// Top level of the source lexer tokenizer: byte scanner, counters and result queue.
`timescale 1ns / 1ps

// Takes one source byte per cycle (or an end-of-input mark) and emits tokens:
// keywords, identifiers, numbers, single-character tokens and eof, each tagged
// with the line and column counters. A byte is scanned in the cycle of its
// transfer and its tokens land in a four-entry result queue that drives the
// result channel; the queue drains one token per cycle while its receiver is ready.
// Most bytes give zero or one token, so the block sustains one byte per cycle. A
// byte that ends a pending identifier or number and is itself a token (and the end
// mark after a pending token) gives two tokens; the input takes a byte only while
// at least two queue entries are free, so a long run of such bytes is held back
// by the single result port.
module source_lexer_tokenizer_core #(
   parameter int PREFIX_CHARS    = slt_pkg::PREFIX_CHARS_DEF,
   parameter int MANTISSA_DIGITS = slt_pkg::MANTISSA_DIGITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   slt_req_if.sink      req_if,
   slt_rsp_if.source    rsp_if
);
   import slt_pkg::*;

   localparam int          PFX_W     = 8 * PREFIX_CHARS;
   localparam logic [63:0] MANT_MAX  = mant_max(MANTISSA_DIGITS);
   localparam int          ACC_W     = $clog2(MANT_MAX + 64'd1);
   localparam int          SUM_W     = ACC_W + 4;
   localparam int          QDEPTH    = 4;
   localparam int          QCNT_W    = $clog2(QDEPTH + 1);

   // Scanner modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_IDENT   = 2'd1;
   localparam logic [1:0] MODE_NUMBER  = 2'd2;
   localparam logic [1:0] MODE_COMMENT = 2'd3;

   // Scanner state
   logic [1:0]        mode_ff, mode_in;
   logic [PFX_W-1:0]  chars_ff, chars_in;
   logic [7:0]        count_ff, count_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [7:0]        frac_ff, frac_in;
   logic              dot_ff, dot_in;
   logic              sat_ff, sat_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              started_ff, started_in;

   // Result queue
   slt_result_type    q_ff [QDEPTH];
   slt_result_type    q_in [QDEPTH];
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   logic              accept, pop;
   logic [BYTE_W-1:0] b;
   logic              is_sp, is_dig, is_alp;
   logic [3:0]        digit;
   logic [SUM_W-1:0]  sum;
   logic              add_sat;
   logic [COL_W-1:0]  col_s;
   logic              do_idle, flush_id, flush_num, tok_char, tok_eof;
   logic [KIND_W-1:0] ident_kind;
   logic [63:0]       acc_wide;
   slt_result_type    flush_res, second_res, r0, r1;
   logic [1:0]        n_res;
   logic [QCNT_W-1:0] base;

   assign accept = req_if.valid && req_if.ready;
   assign pop    = rsp_if.valid && rsp_if.ready;
   assign b      = req_if.char_byte;

   // Classify the byte
   assign is_sp  = (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
   assign is_dig = (b >= 8'h30) && (b <= 8'h39);
   assign is_alp = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
   assign digit  = 4'(b - 8'h30);

   // Accumulate one decimal digit, saturate above the mantissa limit
   assign sum     = SUM_W'(acc_ff) * SUM_W'(10) + SUM_W'(digit);
   assign add_sat = sum > SUM_W'(MANT_MAX);

   // Leading virtual space bumps the column on the first byte
   assign col_s = (!started_ff && col_ff != '1) ? col_ff + COL_W'(1) : col_ff;

   // Match the pending identifier against the keywords
   always_comb begin
      ident_kind = TOK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (count_ff == KW_LEN[k] && PREFIX_W'(chars_ff) == PREFIX_W'(KW_TEXT[k])) begin
            ident_kind = TOK_FUN + KIND_W'(k);
         end
      end
   end

   assign acc_wide = 64'(acc_ff);

   // Scan one byte: next state and which tokens it yields
   always_comb begin
      mode_in    = mode_ff;
      chars_in   = chars_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      frac_in    = frac_ff;
      dot_in     = dot_ff;
      sat_in     = sat_ff;
      line_in    = line_ff;
      col_in     = col_s;
      started_in = 1'b1;
      do_idle    = 1'b0;
      flush_id   = 1'b0;
      flush_num  = 1'b0;
      tok_char   = 1'b0;
      tok_eof    = 1'b0;

      if (req_if.end_of_input) begin
         flush_id  = (mode_ff == MODE_IDENT);
         flush_num = (mode_ff == MODE_NUMBER);
         mode_in   = MODE_IDLE;
         tok_eof   = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_IDENT: begin
               if (is_alp || is_dig) begin
                  for (int i = 0; i < PREFIX_CHARS; i++) begin
                     if (count_ff == 8'(i)) chars_in[8*i +: 8] = b;
                  end
                  if (count_ff != 8'hff) count_in = count_ff + 8'd1;
                  if (col_s != '1) col_in = col_s + COL_W'(1);
               end else begin
                  flush_id = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_dig) begin
                  acc_in = add_sat ? ACC_W'(MANT_MAX) : ACC_W'(sum);
                  if (add_sat) sat_in = 1'b1;
                  if (dot_ff && frac_ff != 8'hff) frac_in = frac_ff + 8'd1;
               end else if (b == CH_DOT && !dot_ff) begin
                  dot_in = 1'b1;
               end else begin
                  flush_num = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (b == CH_LF || b == CH_CR) do_idle = 1'b1;
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // Byte seen between tokens
         if (do_idle) begin
            mode_in = MODE_IDLE;
            priority if (is_sp) begin
               if (b == CH_LF) begin
                  if (line_ff != '1) line_in = line_ff + LINE_W'(1);
                  col_in = COL_W'(1);
               end else if (col_s != '1) begin
                  col_in = col_s + COL_W'(1);
               end
            end else if (is_alp) begin
               mode_in  = MODE_IDENT;
               chars_in = PFX_W'(b);
               count_in = 8'd1;
            end else if (is_dig) begin
               mode_in = MODE_NUMBER;
               acc_in  = ACC_W'(digit);
               frac_in = 8'd0;
               dot_in  = 1'b0;
               sat_in  = 1'b0;
            end else if (b == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               tok_char = 1'b1;
            end
         end
      end
   end

   // Build the finished token and the token formed by this byte
   always_comb begin
      flush_res                 = '0;
      flush_res.line_number     = line_ff;
      flush_res.column_number   = col_s;
      if (flush_id) begin
         flush_res.token_kind   = ident_kind;
         flush_res.ident_prefix = PREFIX_W'(chars_ff);
         flush_res.ident_length = count_ff;
      end else begin
         flush_res.token_kind      = TOK_NUM;
         flush_res.mantissa        = acc_wide[MANT_W-1:0];
         flush_res.fraction_digits = frac_ff;
         flush_res.number_overflow = sat_ff;
      end

      second_res               = '0;
      second_res.line_number   = line_ff;
      second_res.column_number = col_s;
      second_res.last          = 1'b1;
      if (tok_char) begin
         second_res.token_kind = TOK_CHAR;
         second_res.char_code  = b;
      end else begin
         second_res.token_kind = TOK_EOF;
      end

      n_res = 2'(flush_id || flush_num) + 2'(tok_char || tok_eof);
      if (flush_id || flush_num) begin
         r0      = flush_res;
         r0.last = !(tok_char || tok_eof);
      end else begin
         r0 = second_res;
      end
      r1 = second_res;
   end

   // Advance the result queue: drop the head on transfer, append new tokens
   always_comb begin
      base = cnt_ff - QCNT_W'(pop);
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) q_in[i] = q_ff[(i + 1) % QDEPTH];
         else q_in[i] = q_ff[i];
         if (accept && n_res != 2'd0 && QCNT_W'(i) == base) q_in[i] = r0;
         if (accept && n_res == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) q_in[i] = r1;
      end
      cnt_in = base + (accept ? QCNT_W'(n_res) : QCNT_W'(0));
   end

   // Control and scanner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         chars_ff   <= '0;
         count_ff   <= '0;
         acc_ff     <= '0;
         frac_ff    <= '0;
         dot_ff     <= 1'b0;
         sat_ff     <= 1'b0;
         line_ff    <= LINE_W'(1);
         col_ff     <= '0;
         started_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            chars_ff   <= chars_in;
            count_ff   <= count_in;
            acc_ff     <= acc_in;
            frac_ff    <= frac_in;
            dot_ff     <= dot_in;
            sat_ff     <= sat_in;
            line_ff    <= line_in;
            col_ff     <= col_in;
            started_ff <= started_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Queue payload holds no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // Drive the channels
   assign req_if.ready           = cnt_ff <= QCNT_W'(QDEPTH - 2);
   assign rsp_if.valid           = cnt_ff != '0;
   assign rsp_if.token_kind      = q_ff[0].token_kind;
   assign rsp_if.char_code       = q_ff[0].char_code;
   assign rsp_if.ident_prefix    = q_ff[0].ident_prefix;
   assign rsp_if.ident_length    = q_ff[0].ident_length;
   assign rsp_if.mantissa        = q_ff[0].mantissa;
   assign rsp_if.fraction_digits = q_ff[0].fraction_digits;
   assign rsp_if.number_overflow = q_ff[0].number_overflow;
   assign rsp_if.line_number     = q_ff[0].line_number;
   assign rsp_if.column_number   = q_ff[0].column_number;
   assign rsp_if.last            = q_ff[0].last;

   // Queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue count beyond depth");

   // End mark always leaves the scanner idle
   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.end_of_input |=> mode_ff == MODE_IDLE)
      else $error("scanner not idle after end of input");

   // A byte that yields tokens makes a result visible next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept && n_res != 2'd0 |=> rsp_if.valid)
      else $error("token lost after transfer");

   // Line counter starts at one and never wraps to zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter reached zero");

endmodule
